// ===== rtl/spc_pkg.sv =====
// Shared types and constants for the sphere proximity clustering block.
package spc_pkg;

    localparam int MAX_SPHERES = 32;
    localparam int IDX_W       = $clog2(MAX_SPHERES);
    localparam int CNT_W       = $clog2(MAX_SPHERES + 1);

    localparam int COORD_W   = 16;
    localparam int RADIUS_W  = 15;
    localparam int GAP_W     = 15;
    localparam int OUT_IDX_W = 5;
    localparam int SPHERE_W  = 3 * COORD_W + RADIUS_W;

    // reach = r_a + r_b + gap needs two extra bits
    localparam int REACH_W = RADIUS_W + 2;
    localparam int SQ_W    = 2 * COORD_W;
    // both the sum of three squares and reach squared fit here
    localparam int DIST_W  = 2 * REACH_W;

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 16;
    localparam int M_USER_W = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef struct packed {
        logic [RADIUS_W-1:0]       r;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } sphere_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } touch_res_t;

endpackage

// ===== rtl/spc_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module spc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port; read data holds when idle
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/spc_touch.sv =====
// Three-stage exact integer sphere contact test.
module spc_touch (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  spc_pkg::sphere_t          sph_a,
    input  spc_pkg::sphere_t          sph_b,
    input  logic [spc_pkg::GAP_W-1:0] gap,
    output spc_pkg::touch_res_t       res
);

    localparam int DIFF_W = spc_pkg::COORD_W + 1;

    logic                              v0_reg, v1_reg, v2_reg;
    logic signed [DIFF_W-1:0]          dx_reg, dy_reg, dz_reg;
    logic [spc_pkg::REACH_W-1:0]       reach_reg;
    logic [spc_pkg::SQ_W-1:0]          sqx_reg, sqy_reg, sqz_reg;
    logic [spc_pkg::DIST_W-1:0]        reach_sq_reg;
    logic                              hit_reg;
    logic [DIFF_W-1:0]                 mx, my, mz;
    logic [spc_pkg::DIST_W-1:0]        dist_sq;

    // magnitudes of the differences
    always_comb begin
        mx = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
        my = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
        mz = dz_reg[DIFF_W-1] ? DIFF_W'(-dz_reg) : DIFF_W'(dz_reg);
        dist_sq = spc_pkg::DIST_W'(sqx_reg) + spc_pkg::DIST_W'(sqy_reg)
                + spc_pkg::DIST_W'(sqz_reg);
    end

    // advance the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v0_reg <= start;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // stage 0: differences and reach; stage 1: squares; stage 2: compare
    always_ff @(posedge aclk) begin
        dx_reg    <= DIFF_W'(sph_a.x) - DIFF_W'(sph_b.x);
        dy_reg    <= DIFF_W'(sph_a.y) - DIFF_W'(sph_b.y);
        dz_reg    <= DIFF_W'(sph_a.z) - DIFF_W'(sph_b.z);
        reach_reg <= spc_pkg::REACH_W'(sph_a.r) + spc_pkg::REACH_W'(sph_b.r)
                   + spc_pkg::REACH_W'(gap);

        sqx_reg      <= mx[spc_pkg::COORD_W-1:0] * mx[spc_pkg::COORD_W-1:0];
        sqy_reg      <= my[spc_pkg::COORD_W-1:0] * my[spc_pkg::COORD_W-1:0];
        sqz_reg      <= mz[spc_pkg::COORD_W-1:0] * mz[spc_pkg::COORD_W-1:0];
        reach_sq_reg <= spc_pkg::DIST_W'(reach_reg) * spc_pkg::DIST_W'(reach_reg);

        hit_reg <= (dist_sq <= reach_sq_reg);
    end

    assign res.valid = v2_reg;
    assign res.hit   = hit_reg;

endmodule

// ===== rtl/sphere_proximity_clustering.sv =====
// Top level of the sphere proximity clustering block.
//
// Usage: each input beat on the s_ channel carries a command in s_tuser.
// A load beat stores one sphere (center and radius in s_tdata) in the next
// free slot; when all slots are taken the sphere is dropped and the overflow
// flag is set. A run beat groups the stored spheres into touching clusters
// and emits one m_ beat per sphere, cluster by cluster in ascending root
// order, members ascending; m_tlast marks the final beat of a run. The run
// clears the store and the overflow flag. cfg_data sets the extra surface gap.
// A load beat is taken whenever the block is idle. A run does link init,
// then a pair scan with path-halving finds on each join, then root
// flattening, a root scan and the output pass, all paced by the single
// read port of the parent-link memory. No input is accepted during a run.
// The result sits in an output register; a stalled receiver holds the
// output scan in place with no loss. Reset empties the store, clears the
// overflow flag, the gap and the output valid. No clearing pass is needed.
module sphere_proximity_clustering (
    input  logic                         aclk,
    input  logic                         aresetn,
    // config write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [spc_pkg::GAP_W-1:0]    cfg_data,     // extra surface gap
    // input channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [spc_pkg::S_DATA_W-1:0] s_tdata,      // center_x, center_y, center_z, radius
    input  logic [0:0]                   s_tuser,      // command
    // result channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [spc_pkg::M_DATA_W-1:0] m_tdata,      // sphere_index, component_index
    output logic [spc_pkg::M_USER_W-1:0] m_tuser,      // last_of_component, overflow
    output logic                         m_tlast       // last
);

    localparam int IW = spc_pkg::IDX_W;
    localparam int CW = spc_pkg::CNT_W;
    localparam int OW = spc_pkg::OUT_IDX_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_PI_RD = 4'd2;
    localparam logic [3:0] ST_PI_WT = 4'd3;
    localparam logic [3:0] ST_PJ_RD = 4'd4;
    localparam logic [3:0] ST_PJ_WT = 4'd5;
    localparam logic [3:0] ST_PJ_TW = 4'd6;
    localparam logic [3:0] ST_F_P   = 4'd7;
    localparam logic [3:0] ST_F_G   = 4'd8;
    localparam logic [3:0] ST_RT_RD = 4'd9;
    localparam logic [3:0] ST_EM_R  = 4'd10;
    localparam logic [3:0] ST_EM_RW = 4'd11;
    localparam logic [3:0] ST_EM_I  = 4'd12;
    localparam logic [3:0] ST_EM_IW = 4'd13;
    localparam logic [3:0] ST_DONE  = 4'd14;

    localparam logic [1:0] FIND_A = 2'd0;
    localparam logic [1:0] FIND_B = 2'd1;
    localparam logic [1:0] FIND_R = 2'd2;

    logic [3:0]                 state_reg, state_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       ovf_reg, ovf_next;
    logic [spc_pkg::GAP_W-1:0]  gap_reg;
    logic [CW-1:0]              i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [CW-1:0]              e_reg, e_next, comp_reg, comp_next;
    logic [CW-1:0]              emit_reg, emit_next;
    logic [IW-1:0]              x_reg, x_next, ra_reg, ra_next;
    logic [IW-1:0]              pend_idx_reg, pend_idx_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [1:0]                 sel_reg, sel_next;
    spc_pkg::sphere_t           sph_i_reg, sph_i_next;

    logic                       out_valid_reg, out_valid_next;
    logic [OW-1:0]              out_sidx_reg, out_sidx_next;
    logic [OW-1:0]              out_comp_reg, out_comp_next;
    logic                       out_loc_reg, out_loc_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_ovf_reg, out_ovf_next;

    logic                       st_we, st_re;
    logic [IW-1:0]              st_waddr, st_raddr;
    spc_pkg::sphere_t           st_wdata, st_rdata;
    logic [spc_pkg::SPHERE_W-1:0] st_rdata_raw;
    logic                       pl_we, pl_re;
    logic [IW-1:0]              pl_waddr, pl_raddr, pl_wdata, pl_rdata;

    logic                       t_start;
    spc_pkg::touch_res_t        t_res;
    logic                       out_free;
    logic                       push, push_loc;

    spc_ram #(.WIDTH(spc_pkg::SPHERE_W), .DEPTH(spc_pkg::MAX_SPHERES)) u_store (
        .clk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .re(st_re), .raddr(st_raddr), .rdata(st_rdata_raw)
    );
    assign st_rdata = spc_pkg::sphere_t'(st_rdata_raw);

    spc_ram #(.WIDTH(IW), .DEPTH(spc_pkg::MAX_SPHERES)) u_links (
        .clk(aclk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
        .re(pl_re), .raddr(pl_raddr), .rdata(pl_rdata)
    );

    spc_touch u_touch (
        .aclk(aclk), .aresetn(aresetn), .start(t_start),
        .sph_a(sph_i_reg), .sph_b(st_rdata), .gap(gap_reg), .res(t_res)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(spc_pkg::M_DATA_W - 2 * OW){1'b0}}, out_comp_reg, out_sidx_reg};
    assign m_tuser  = {out_ovf_reg, out_loc_reg};
    assign m_tlast  = out_last_reg;

    // sequencer: load, link init, pair scan, root flatten, output scan
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        e_next          = e_reg;
        comp_next       = comp_reg;
        emit_next       = emit_reg;
        x_next          = x_reg;
        ra_next         = ra_reg;
        sel_next        = sel_reg;
        pend_idx_next   = pend_idx_reg;
        pend_valid_next = pend_valid_reg;
        sph_i_next      = sph_i_reg;

        st_we    = 1'b0;
        st_waddr = cnt_reg[IW-1:0];
        st_wdata = '{r: s_tdata[62:48], z: s_tdata[47:32], y: s_tdata[31:16],
                     x: s_tdata[15:0]};
        st_re    = 1'b0;
        st_raddr = i_reg[IW-1:0];
        pl_we    = 1'b0;
        pl_waddr = x_reg;
        pl_wdata = x_reg;
        pl_re    = 1'b0;
        pl_raddr = x_reg;
        t_start  = 1'b0;
        push     = 1'b0;
        push_loc = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == spc_pkg::CMD_LOAD) begin
                        if (cnt_reg < CW'(spc_pkg::MAX_SPHERES)) begin
                            st_we    = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end else begin
                        k_next     = '0;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                if (k_reg == cnt_reg) begin
                    i_next     = '0;
                    state_next = ST_PI_RD;
                end else begin
                    pl_we    = 1'b1;
                    pl_waddr = k_reg[IW-1:0];
                    pl_wdata = k_reg[IW-1:0];
                    k_next   = k_reg + 1'b1;
                end
            end
            ST_PI_RD: begin
                if (i_reg + 1'b1 >= cnt_reg) begin
                    k_next     = '0;
                    state_next = ST_RT_RD;
                end else begin
                    st_re      = 1'b1;
                    st_raddr   = i_reg[IW-1:0];
                    state_next = ST_PI_WT;
                end
            end
            ST_PI_WT: begin
                sph_i_next = st_rdata;
                j_next     = i_reg + 1'b1;
                state_next = ST_PJ_RD;
            end
            ST_PJ_RD: begin
                st_re      = 1'b1;
                st_raddr   = j_reg[IW-1:0];
                state_next = ST_PJ_WT;
            end
            ST_PJ_WT: begin
                t_start    = 1'b1;
                state_next = ST_PJ_TW;
            end
            ST_PJ_TW: begin
                if (t_res.valid) begin
                    if (t_res.hit) begin
                        pl_re      = 1'b1;
                        pl_raddr   = i_reg[IW-1:0];
                        x_next     = i_reg[IW-1:0];
                        sel_next   = FIND_A;
                        state_next = ST_F_P;
                    end else if (j_reg + 1'b1 < cnt_reg) begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_PJ_RD;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_PI_RD;
                    end
                end
            end
            ST_F_P: begin
                if (pl_rdata == x_reg) begin
                    unique case (sel_reg)
                        FIND_A: begin
                            ra_next  = x_reg;
                            x_next   = j_reg[IW-1:0];
                            pl_re    = 1'b1;
                            pl_raddr = j_reg[IW-1:0];
                            sel_next = FIND_B;
                        end
                        FIND_B: begin
                            // hang root of i under root of j
                            pl_we    = 1'b1;
                            pl_waddr = ra_reg;
                            pl_wdata = x_reg;
                            if (j_reg + 1'b1 < cnt_reg) begin
                                j_next     = j_reg + 1'b1;
                                state_next = ST_PJ_RD;
                            end else begin
                                i_next     = i_reg + 1'b1;
                                state_next = ST_PI_RD;
                            end
                        end
                        FIND_R: begin
                            pl_we      = 1'b1;
                            pl_waddr   = k_reg[IW-1:0];
                            pl_wdata   = x_reg;
                            k_next     = k_reg + 1'b1;
                            state_next = ST_RT_RD;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end else begin
                    pl_re      = 1'b1;
                    pl_raddr   = pl_rdata;
                    state_next = ST_F_G;
                end
            end
            ST_F_G: begin
                // path halving: point x at its grandparent, move on to it
                pl_we      = 1'b1;
                pl_waddr   = x_reg;
                pl_wdata   = pl_rdata;
                pl_re      = 1'b1;
                pl_raddr   = pl_rdata;
                x_next     = pl_rdata;
                state_next = ST_F_P;
            end
            ST_RT_RD: begin
                if (k_reg == cnt_reg) begin
                    k_next          = '0;
                    comp_next       = '0;
                    emit_next       = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_EM_R;
                end else begin
                    pl_re      = 1'b1;
                    pl_raddr   = k_reg[IW-1:0];
                    x_next     = k_reg[IW-1:0];
                    sel_next   = FIND_R;
                    state_next = ST_F_P;
                end
            end
            ST_EM_R: begin
                if (k_reg == cnt_reg) begin
                    state_next = ST_DONE;
                end else begin
                    pl_re      = 1'b1;
                    pl_raddr   = k_reg[IW-1:0];
                    state_next = ST_EM_RW;
                end
            end
            ST_EM_RW: begin
                if (pl_rdata == k_reg[IW-1:0]) begin
                    e_next     = '0;
                    state_next = ST_EM_I;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_EM_R;
                end
            end
            ST_EM_I: begin
                if (e_reg == cnt_reg) begin
                    // flush the final member of this cluster
                    if (out_free) begin
                        push            = 1'b1;
                        push_loc        = 1'b1;
                        pend_valid_next = 1'b0;
                        comp_next       = comp_reg + 1'b1;
                        k_next          = k_reg + 1'b1;
                        state_next      = ST_EM_R;
                    end
                end else begin
                    pl_re      = 1'b1;
                    pl_raddr   = e_reg[IW-1:0];
                    state_next = ST_EM_IW;
                end
            end
            ST_EM_IW: begin
                if (pl_rdata == k_reg[IW-1:0]) begin
                    if (!pend_valid_reg) begin
                        pend_valid_next = 1'b1;
                        pend_idx_next   = e_reg[IW-1:0];
                        e_next          = e_reg + 1'b1;
                        state_next      = ST_EM_I;
                    end else if (out_free) begin
                        push          = 1'b1;
                        pend_idx_next = e_reg[IW-1:0];
                        e_next        = e_reg + 1'b1;
                        state_next    = ST_EM_I;
                    end
                end else begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_EM_I;
                end
            end
            ST_DONE: begin
                cnt_next   = '0;
                ovf_next   = 1'b0;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        // count emitted beats for the run-last marker
        if (push) begin
            emit_next = emit_reg + 1'b1;
        end
    end

    // output register: load on push, drop when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        out_sidx_next  = out_sidx_reg;
        out_comp_next  = out_comp_reg;
        out_loc_next   = out_loc_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        if (push) begin
            out_valid_next = 1'b1;
            out_sidx_next  = OW'(pend_idx_reg);
            out_comp_next  = OW'(comp_reg);
            out_loc_next   = push_loc;
            out_last_next  = (CW'(emit_reg + 1'b1) == cnt_reg);
            out_ovf_next   = ovf_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            gap_reg        <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_valid && cfg_ready) begin
                gap_reg <= cfg_data;
            end
        end
    end

    // counters and payload
    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        e_reg        <= e_next;
        comp_reg     <= comp_next;
        emit_reg     <= emit_next;
        x_reg        <= x_next;
        ra_reg       <= ra_next;
        sel_reg      <= sel_next;
        pend_idx_reg <= pend_idx_next;
        sph_i_reg    <= sph_i_next;
        out_sidx_reg <= out_sidx_next;
        out_comp_reg <= out_comp_next;
        out_loc_reg  <= out_loc_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

endmodule

// ===== rtl/spc_checker.sv =====
// Port-level checks for the sphere proximity clustering block.
module spc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [0:0]                   s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready
);

    // a result beat holds until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped under stall");

    // a run beat closes the input right after it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == spc_pkg::CMD_RUN) |=> !s_tready)
        else $error("input open right after run beat");

    // new results only appear while a run is busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result beat appeared while idle");

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sphere_proximity_clustering spc_checker u_spc_checker (.*);

// ===== dv/sphere_proximity_clustering_tb.sv =====
// Self-checking testbench for the sphere proximity clustering block.
module sphere_proximity_clustering_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int RANDOM_ITEMS   = 400;
    localparam int HOLD_OFF       = 4000;

    typedef struct packed {
        logic [4:0] sphere_idx;
        logic [4:0] comp_idx;
        logic       comp_last;
        logic       run_last;
        logic       ovf;
    } cluster_beat_t;

    typedef struct {
        logic                         cmd;
        logic [spc_pkg::COORD_W-1:0]  x, y, z;
        logic [spc_pkg::RADIUS_W-1:0] r;
        bit                           typed;
        cluster_beat_t                want;
    } stim_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [spc_pkg::GAP_W-1:0]      cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [spc_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic [0:0]                     s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [spc_pkg::M_DATA_W-1:0]   m_tdata;
    logic [spc_pkg::M_USER_W-1:0]   m_tuser;
    logic                           m_tlast;

    sphere_proximity_clustering u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // Shadow copy of the block state
    logic signed [spc_pkg::COORD_W-1:0] cx[spc_pkg::MAX_SPHERES];
    logic signed [spc_pkg::COORD_W-1:0] cy[spc_pkg::MAX_SPHERES];
    logic signed [spc_pkg::COORD_W-1:0] cz[spc_pkg::MAX_SPHERES];
    logic [spc_pkg::RADIUS_W-1:0]       crad[spc_pkg::MAX_SPHERES];
    int                                 link[spc_pkg::MAX_SPHERES];
    int                                 stored_cnt = 0;
    bit                                 dropped = 1'b0;
    logic [spc_pkg::GAP_W-1:0]          gap_now = '0;

    cluster_beat_t pending_beats[$];
    int  errors = 0, sent = 0, beats_seen = 0, runs_sent = 0, ovf_beats = 0;
    bit  calm = 1'b0;
    bit  stim_done = 1'b0;
    int  quiet_cycles = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int find_root(int v);
        while (link[v] != v) begin
            link[v] = link[link[v]];
            v = link[v];
        end
        return v;
    endfunction

    // Model one accepted beat; a run returns its cluster beats in order
    task automatic cluster_predict(input logic cmd,
                                   input logic [spc_pkg::S_DATA_W-1:0] data,
                                   output cluster_beat_t res[$]);
        int     root[spc_pkg::MAX_SPHERES];
        int     tail[spc_pkg::MAX_SPHERES];
        int     n, comp, emitted, ra, rb;
        longint dx, dy, dz, reach;
        cluster_beat_t b;
        res.delete();
        if (cmd == spc_pkg::CMD_LOAD) begin
            if (stored_cnt < spc_pkg::MAX_SPHERES) begin
                cx[stored_cnt]   = data[15:0];
                cy[stored_cnt]   = data[31:16];
                cz[stored_cnt]   = data[47:32];
                crad[stored_cnt] = data[62:48];
                stored_cnt++;
            end else begin
                dropped = 1'b1;
            end
            return;
        end
        n = stored_cnt;
        for (int i = 0; i < n; i++) link[i] = i;
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
                dx = longint'(cx[i]) - longint'(cx[j]);
                dy = longint'(cy[i]) - longint'(cy[j]);
                dz = longint'(cz[i]) - longint'(cz[j]);
                reach = longint'(crad[i]) + longint'(crad[j]) + longint'(gap_now);
                if (dx*dx + dy*dy + dz*dz <= reach*reach) begin
                    ra = find_root(i);
                    rb = find_root(j);
                    link[ra] = rb;
                end
            end
        end
        for (int i = 0; i < n; i++) root[i] = find_root(i);
        for (int i = 0; i < n; i++) tail[root[i]] = i;
        comp = 0;
        emitted = 0;
        for (int r = 0; r < n; r++) begin
            if (root[r] != r) continue;
            for (int i = 0; i < n; i++) begin
                if (root[i] != r) continue;
                b.sphere_idx = i[4:0];
                b.comp_idx   = comp[4:0];
                b.comp_last  = (tail[r] == i);
                b.run_last   = (emitted + 1 == n);
                b.ovf        = dropped;
                res.insert(res.size(), b);
                emitted++;
            end
            comp++;
        end
        stored_cnt = 0;
        dropped = 1'b0;
    endtask

    // Offer one beat, hold it until accepted, then predict it
    task automatic send_beat(input logic cmd, input logic [spc_pkg::S_DATA_W-1:0] data,
                             input bit typed, input cluster_beat_t want);
        cluster_beat_t res[$];
        int gap_len;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap_len = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap_len) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cluster_predict(cmd, data, res);
        if (cmd == spc_pkg::CMD_RUN) runs_sent++;
        if (typed) pending_beats.insert(pending_beats.size(), want);
        else foreach (res[k]) pending_beats.insert(pending_beats.size(), res[k]);
        sent++;
    endtask

    function automatic logic [spc_pkg::S_DATA_W-1:0] pack_sphere(logic [15:0] x,
                                                                 logic [15:0] y,
                                                                 logic [15:0] z,
                                                                 logic [14:0] r);
        return {1'b0, r, z, y, x};
    endfunction

    // Wait for the block to drain, then change the gap
    task automatic write_gap(input logic [spc_pkg::GAP_W-1:0] v);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        gap_now = v;
        cfg_valid <= 1'b0;
    endtask

    // One batch of loads followed by a run
    task automatic random_batch(input int n, input bit clustered);
        logic [15:0] hx[3], hy[3], hz[3];
        int h;
        cluster_beat_t none;
        none = '0;
        for (int k = 0; k < 3; k++) begin
            hx[k] = 16'($urandom); hy[k] = 16'($urandom); hz[k] = 16'($urandom);
        end
        for (int k = 0; k < n; k++) begin
            h = $urandom_range(0, 2);
            if (clustered && $urandom_range(0, 7) != 0)
                send_beat(spc_pkg::CMD_LOAD,
                          pack_sphere(16'(hx[h] + $urandom_range(0, 800) - 400),
                                      16'(hy[h] + $urandom_range(0, 800) - 400),
                                      16'(hz[h] + $urandom_range(0, 800) - 400),
                                      15'($urandom_range(0, 300))), 1'b0, none);
            else
                send_beat(spc_pkg::CMD_LOAD,
                          pack_sphere(16'($urandom), 16'($urandom), 16'($urandom),
                                      15'($urandom)),
                          1'b0, none);
        end
        // center and radius bits are junk on a run
        send_beat(spc_pkg::CMD_RUN, {1'b0, 63'($urandom) << 32 | 63'($urandom)}, 1'b0, none);
    endtask

    stim_row_t dir_rows[$];

    task automatic add_row(input logic cmd, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z, input logic [14:0] r);
        stim_row_t row;
        row.cmd = cmd; row.x = x; row.y = y; row.z = z; row.r = r;
        row.typed = 1'b0; row.want = '0;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // Stimulus
    initial begin
        int n, pick;
        stim_row_t row;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // run on an empty store
        add_row(spc_pkg::CMD_RUN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF);
        // one sphere at the low corner: a lone cluster
        add_row(spc_pkg::CMD_LOAD, 16'h8000, 16'h8000, 16'h8000, 15'h0);
        add_row(spc_pkg::CMD_RUN, 16'h0, 16'h0, 16'h0, 15'h0);
        dir_rows[$].typed = 1'b1;
        dir_rows[$].want  = '{sphere_idx: 0, comp_idx: 0, comp_last: 1, run_last: 1, ovf: 0};
        // opposite corners with largest radii stay apart; coincident centers touch
        add_row(spc_pkg::CMD_LOAD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF);
        add_row(spc_pkg::CMD_LOAD, 16'h8000, 16'h8000, 16'h8000, 15'h7FFF);
        add_row(spc_pkg::CMD_LOAD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h0);
        add_row(spc_pkg::CMD_RUN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF);
        // exact contact versus one unit short, and a chain joined out of order
        add_row(spc_pkg::CMD_LOAD, 16'd0, 16'd0, 16'd0, 15'd100);
        add_row(spc_pkg::CMD_LOAD, 16'd300, 16'd0, 16'd0, 15'd200);
        add_row(spc_pkg::CMD_LOAD, 16'd0, 16'd2000, 16'd0, 15'd100);
        add_row(spc_pkg::CMD_LOAD, 16'd0, 16'd2301, 16'd0, 15'd200);
        add_row(spc_pkg::CMD_LOAD, 16'd600, 16'd0, 16'd0, 15'd100);
        add_row(spc_pkg::CMD_LOAD, 16'd0, 16'd0, 16'd0, 15'd0);
        add_row(spc_pkg::CMD_LOAD, -16'sd50, 16'd0, 16'd0, 15'd50);
        add_row(spc_pkg::CMD_RUN, 16'h0, 16'h0, 16'h0, 15'h0);

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            send_beat(row.cmd, pack_sphere(row.x, row.y, row.z, row.r), row.typed, row.want);
        end

        // random phases through the gap extremes
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_gap('1);
                1: write_gap('0);
                2: write_gap(spc_pkg::GAP_W'($urandom_range(0, 2000)));
                default: write_gap(spc_pkg::GAP_W'($urandom));
            endcase
            while (sent < 20 + (phase + 1) * RANDOM_ITEMS / 4) begin
                if (sent > 20 + RANDOM_ITEMS * 85 / 100) calm = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 5)       n = 0;
                else if (pick < 65) n = $urandom_range(1, 10);
                else if (pick < 80) n = $urandom_range(11, 31);
                else if (pick < 90) n = spc_pkg::MAX_SPHERES;
                else                n = $urandom_range(spc_pkg::MAX_SPHERES + 1,
                                                       spc_pkg::MAX_SPHERES + 4);
                random_batch(n, $urandom_range(0, 3) != 0);
            end
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, one long hold-off, none at the end
    initial begin
        bit held = 1'b0;
        int len;
        forever begin
            @(posedge aclk);
            if (!held && sent > 150) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                len = $urandom_range(1, 17);
                m_tready <= 1'b0;
                repeat (len) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Check result beats and watch for a hang
    always @(posedge aclk) begin
        cluster_beat_t exp_b;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                beats_seen <= beats_seen + 1;
                if (m_tuser[1]) ovf_beats <= ovf_beats + 1;
                if (pending_beats.size() == 0) begin
                    $error("unexpected result beat sphere_index=%0d", m_tdata[4:0]);
                    errors++;
                end else begin
                    exp_b = pending_beats.pop_front();
                    if (m_tdata[4:0] !== exp_b.sphere_idx) begin
                        $error("sphere_index exp %0d got %0d", exp_b.sphere_idx, m_tdata[4:0]);
                        errors++;
                    end
                    if (m_tdata[9:5] !== exp_b.comp_idx) begin
                        $error("component_index exp %0d got %0d", exp_b.comp_idx, m_tdata[9:5]);
                        errors++;
                    end
                    if (m_tuser[0] !== exp_b.comp_last) begin
                        $error("last_of_component exp %0d got %0d", exp_b.comp_last, m_tuser[0]);
                        errors++;
                    end
                    if (m_tlast !== exp_b.run_last) begin
                        $error("last exp %0d got %0d", exp_b.run_last, m_tlast);
                        errors++;
                    end
                    if (m_tuser[1] !== exp_b.ovf) begin
                        $error("overflow exp %0d got %0d", exp_b.ovf, m_tuser[1]);
                        errors++;
                    end
                end
            end
        end
    end

    // Drain and report
    initial begin
        wait (stim_done);
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("Sent %0d input beats (%0d runs) over four gap settings.", sent, runs_sent);
        $display("Checked %0d cluster beats, %0d flagged overflow.", beats_seen, ovf_beats);
        if (errors == 0 && pending_beats.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/spc_pkg.sv
rtl/spc_ram.sv
rtl/spc_touch.sv
rtl/sphere_proximity_clustering.sv
rtl/spc_checker.sv
dv/sphere_proximity_clustering_tb.sv
